@@ hdl/slin_pkg.sv @@
// Shared types, constants and lookup tables for the sensor linearizer.
`timescale 1ns / 1ps

package slin_pkg;

  // Channel kinds
  typedef enum logic [1:0] {
    KIND_TEMP     = 2'd0,
    KIND_THROTTLE = 2'd1,
    KIND_PRESSURE = 2'd2,
    KIND_BATTERY  = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_THR_LO = 3'd0,
    REG_THR_HI = 3'd1,
    REG_PRS_LO = 3'd2,
    REG_PRS_HI = 3'd3,
    REG_PRS_FS = 3'd4
  } cfg_idx_t;

  localparam int VREF_MV_DEF       = 3300;
  localparam int ADC_FULL_CODE_DEF = 4095;
  localparam int RAW_W             = 12;
  localparam int MVCFG_W           = 12;
  localparam int FS_W              = 14;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 14;

  // Divider geometry: quotient always fits Q_W bits
  localparam int Q_W    = 14;
  localparam int DEN_W  = 12;
  localparam int NUM_W  = Q_W + DEN_W;
  localparam int BASE_W = 12;
  localparam int VALUE_W = 15;

  localparam int VALUE_MAX     = 16383;
  localparam int THR_TOP       = 1000;
  localparam int BATT_MUL      = 49;
  localparam int BATT_DIV      = 10;
  localparam int BATT_SAT      = (VALUE_MAX + 1) * BATT_DIV;
  localparam int NTC_SEGS      = 9;

  // mv stage 4, prep 2, divider 15, output 1
  localparam int LATENCY = 22;

  typedef struct packed {
    logic [MVCFG_W-1:0] thr_lo;
    logic [MVCFG_W-1:0] thr_hi;
    logic [MVCFG_W-1:0] prs_lo;
    logic [MVCFG_W-1:0] prs_hi;
    logic [FS_W-1:0]    prs_fs;
  } cfg_t;

  typedef struct packed {
    logic                     vld;
    kind_t                    kind;
    logic [NUM_W-1:0]         num;
    logic [DEN_W-1:0]         den;
    logic signed [BASE_W-1:0] base;
  } div_req_t;

  typedef struct packed {
    logic                     vld;
    kind_t                    kind;
    logic signed [BASE_W-1:0] base;
    logic [Q_W-1:0]           quo;
  } div_rsp_t;

  // Thermistor breakpoints, millivolts (descending)
  function automatic logic [11:0] ntc_mv(input logic [3:0] idx);
    logic [11:0] v;
    unique case (idx)
      4'd0:    v = 12'd3250;
      4'd1:    v = 12'd3150;
      4'd2:    v = 12'd2900;
      4'd3:    v = 12'd2500;
      4'd4:    v = 12'd1900;
      4'd5:    v = 12'd1350;
      4'd6:    v = 12'd850;
      4'd7:    v = 12'd630;
      4'd8:    v = 12'd480;
      default: v = 12'd270;
    endcase
    return v;
  endfunction

  // Temperatures at the breakpoints, tenths of a degree
  function automatic logic signed [BASE_W-1:0] ntc_temp(input logic [3:0] idx);
    logic signed [BASE_W-1:0] t;
    unique case (idx)
      4'd0:    t = -12'sd400;
      4'd1:    t = -12'sd200;
      4'd2:    t = 12'sd0;
      4'd3:    t = 12'sd200;
      4'd4:    t = 12'sd400;
      4'd5:    t = 12'sd600;
      4'd6:    t = 12'sd800;
      4'd7:    t = 12'sd900;
      4'd8:    t = 12'sd1000;
      default: t = 12'sd1200;
    endcase
    return t;
  endfunction

endpackage

@@ hdl/sensor_linearizer_core.sv @@
// Top level of the sensor linearizer: config registers, pipeline and result register.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+--------------------------
//  input    | start, busy, in_action, in_raw_code          | taken when start & !busy
//  result   | out_valid, out_kind, out_value               | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_wdata   | write when valid & ready
//
// One item per cycle is taken outside reset; each result passes through the millivolt
// and operand stages, the divider load stage, the 14 quotient stages of the divider
// and the result register. busy is high only during reset.
// Reset clears valid bits and loads the register defaults; there is no
// clearing pass. cfg_ready is always high.
`timescale 1ns / 1ps

module sensor_linearizer_core #(
  parameter int VREF_MV       = slin_pkg::VREF_MV_DEF,
  parameter int ADC_FULL_CODE = slin_pkg::ADC_FULL_CODE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_action,
  input  logic [slin_pkg::RAW_W-1:0]          in_raw_code,
  output logic                                out_valid,
  output logic [1:0]                          out_kind,
  output logic signed [slin_pkg::VALUE_W-1:0] out_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slin_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slin_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int MV_W = $clog2((4095 * VREF_MV) / ADC_FULL_CODE + 1);

  slin_pkg::cfg_t     cfg_r;
  logic               accept;
  logic               mv_vld;
  slin_pkg::kind_t    mv_kind;
  logic [MV_W-1:0]    mv;
  slin_pkg::div_req_t req;
  slin_pkg::div_rsp_t rsp;

  logic                                out_valid_r;
  logic [1:0]                          out_kind_r;
  logic signed [slin_pkg::VALUE_W-1:0] out_value_r;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_lo <= 12'd500;
      cfg_r.thr_hi <= 12'd3000;
      cfg_r.prs_lo <= 12'd200;
      cfg_r.prs_hi <= 12'd3100;
      cfg_r.prs_fs <= 14'd2500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (slin_pkg::cfg_idx_t'(cfg_index))
        slin_pkg::REG_THR_LO: cfg_r.thr_lo <= cfg_wdata[11:0];
        slin_pkg::REG_THR_HI: cfg_r.thr_hi <= cfg_wdata[11:0];
        slin_pkg::REG_PRS_LO: cfg_r.prs_lo <= cfg_wdata[11:0];
        slin_pkg::REG_PRS_HI: cfg_r.prs_hi <= cfg_wdata[11:0];
        slin_pkg::REG_PRS_FS: cfg_r.prs_fs <= cfg_wdata;
        default: ;
      endcase
    end
  end

  slin_mv #(
    .VREF_MV       (VREF_MV),
    .ADC_FULL_CODE (ADC_FULL_CODE),
    .MV_W          (MV_W)
  ) u_mv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_kind (slin_pkg::kind_t'(in_action)),
    .in_raw  (in_raw_code),
    .mv_vld  (mv_vld),
    .mv_kind (mv_kind),
    .mv      (mv)
  );

  slin_prep #(
    .MV_W (MV_W)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .mv_vld  (mv_vld),
    .mv_kind (mv_kind),
    .mv      (mv),
    .cfg     (cfg_r),
    .req     (req)
  );

  slin_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // result register: base plus quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rsp.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= rsp.kind;
    out_value_r <= {{(slin_pkg::VALUE_W - slin_pkg::BASE_W){rsp.base[slin_pkg::BASE_W-1]}},
                    rsp.base}
                   + slin_pkg::VALUE_W'(rsp.quo);
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;

endmodule

@@ hdl/slin_mv.sv @@
// Code to millivolt pipeline: raw * VREF / full code by reciprocal multiply and correction.
`timescale 1ns / 1ps

module slin_mv #(
  parameter int VREF_MV       = slin_pkg::VREF_MV_DEF,
  parameter int ADC_FULL_CODE = slin_pkg::ADC_FULL_CODE_DEF,
  parameter int MV_W          = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  slin_pkg::kind_t              in_kind,
  input  logic [slin_pkg::RAW_W-1:0]   in_raw,
  output logic                         mv_vld,
  output slin_pkg::kind_t              mv_kind,
  output logic [MV_W-1:0]              mv
);

  localparam int P_W = $clog2(4095 * VREF_MV + 1);
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / ADC_FULL_CODE);
  localparam logic [P_W-1:0] DIVR = P_W'(ADC_FULL_CODE);

  logic [3:0]            vld_r;
  slin_pkg::kind_t       kind_r [0:3];
  logic [P_W-1:0]        p1_r, p2_r, p3_r, qd_r;
  logic [MV_W-1:0]       q0_r, q0b_r, mv_r;
  logic [P_W+32:0]       pm;
  logic [P_W-1:0]        rmd;

  assign pm  = (P_W+33)'(p1_r) * (P_W+33)'(RECIP);
  assign rmd = p3_r - qd_r;

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // data pipe
  always_ff @(posedge clk) begin
    kind_r[0] <= in_kind;
    kind_r[1] <= kind_r[0];
    kind_r[2] <= kind_r[1];
    kind_r[3] <= kind_r[2];
    // stage 1: product with reference voltage
    p1_r  <= P_W'(32'(in_raw) * 32'(VREF_MV));
    // stage 2: quotient estimate, low by at most one
    q0_r  <= MV_W'(pm >> 32);
    p2_r  <= p1_r;
    // stage 3: back-multiply
    qd_r  <= P_W'(P_W'(q0_r) * DIVR);
    q0b_r <= q0_r;
    p3_r  <= p2_r;
    // stage 4: correction
    mv_r  <= q0b_r + MV_W'(rmd >= DIVR);
  end

  assign mv_vld  = vld_r[3];
  assign mv_kind = kind_r[3];
  assign mv      = mv_r;

endmodule

@@ hdl/slin_prep.sv @@
// Per-kind operand setup: table segment, window compares, battery product, divide operands.
`timescale 1ns / 1ps

module slin_prep #(
  parameter int MV_W = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mv_vld,
  input  slin_pkg::kind_t    mv_kind,
  input  logic [MV_W-1:0]    mv,
  input  slin_pkg::cfg_t     cfg,
  output slin_pkg::div_req_t req
);

  localparam int MX_W = (MV_W > 13) ? MV_W : 13;
  localparam int B_W  = MX_W + 6;

  logic [MX_W-1:0] mvx;
  logic [3:0]      seg;
  logic [11:0]     lo, hi;
  logic [13:0]     top;

  // stage A registers
  logic            a_vld_r;
  slin_pkg::kind_t a_kind_r;
  logic [3:0]      seg_r;
  logic            t_hi_r, t_lo_r, w_le_r, w_ge_r;
  logic [11:0]     mv12_r, wdiff_r, wden_r;
  logic [13:0]     top_r;
  logic [B_W-1:0]  bprod_r;

  // stage B
  slin_pkg::div_req_t req_nxt, req_r;
  logic [11:0]        v0, v1;
  logic signed [11:0] t0, t1, tdelta;
  logic [slin_pkg::NUM_W-1:0] tnum, wnum;

  assign mvx = MX_W'(mv);

  // window limits by kind
  always_comb begin
    if (mv_kind == slin_pkg::KIND_PRESSURE) begin
      lo  = cfg.prs_lo;
      hi  = cfg.prs_hi;
      top = cfg.prs_fs;
    end else begin
      lo  = cfg.thr_lo;
      hi  = cfg.thr_hi;
      top = 14'(slin_pkg::THR_TOP);
    end
  end

  // first segment whose lower breakpoint is at or below mv
  always_comb begin
    seg = 4'(slin_pkg::NTC_SEGS - 1);
    for (int i = slin_pkg::NTC_SEGS - 1; i >= 0; i--) begin
      if (mvx >= MX_W'(slin_pkg::ntc_mv(4'(i + 1)))) seg = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= mv_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_kind_r <= mv_kind;
    seg_r    <= seg;
    t_hi_r   <= mvx >= MX_W'(slin_pkg::ntc_mv(4'd0));
    t_lo_r   <= mvx <= MX_W'(slin_pkg::ntc_mv(4'(slin_pkg::NTC_SEGS)));
    mv12_r   <= mvx[11:0];
    w_le_r   <= mvx <= MX_W'(lo);
    w_ge_r   <= mvx >= MX_W'(hi);
    wdiff_r  <= 12'(mvx - MX_W'(lo));
    wden_r   <= hi - lo;
    top_r    <= top;
    bprod_r  <= B_W'(mvx) * B_W'(slin_pkg::BATT_MUL);
  end

  // segment endpoints and products
  always_comb begin
    v0     = slin_pkg::ntc_mv(seg_r);
    v1     = slin_pkg::ntc_mv(seg_r + 4'd1);
    t0     = slin_pkg::ntc_temp(seg_r);
    t1     = slin_pkg::ntc_temp(seg_r + 4'd1);
    tdelta = t1 - t0;
    tnum   = slin_pkg::NUM_W'(tdelta[7:0]) * slin_pkg::NUM_W'(v0 - mv12_r);
    wnum   = slin_pkg::NUM_W'(wdiff_r) * slin_pkg::NUM_W'(top_r);
  end

  // divide operands: base + num / den
  always_comb begin
    req_nxt.vld  = a_vld_r;
    req_nxt.kind = a_kind_r;
    req_nxt.num  = '0;
    req_nxt.den  = slin_pkg::DEN_W'(1);
    req_nxt.base = '0;
    unique case (a_kind_r)
      slin_pkg::KIND_TEMP: begin
        priority if (t_hi_r) begin
          req_nxt.base = slin_pkg::ntc_temp(4'd0);
        end else if (t_lo_r) begin
          req_nxt.base = slin_pkg::ntc_temp(4'(slin_pkg::NTC_SEGS));
        end else begin
          req_nxt.num  = tnum;
          req_nxt.den  = v0 - v1;
          req_nxt.base = t0;
        end
      end
      slin_pkg::KIND_THROTTLE, slin_pkg::KIND_PRESSURE: begin
        priority if (w_le_r) begin
          req_nxt.num = '0;
        end else if (w_ge_r) begin
          req_nxt.num = slin_pkg::NUM_W'(top_r);
        end else begin
          req_nxt.num = wnum;
          req_nxt.den = wden_r;
        end
      end
      default: begin
        if (bprod_r >= B_W'(slin_pkg::BATT_SAT)) begin
          req_nxt.num = slin_pkg::NUM_W'(slin_pkg::VALUE_MAX);
        end else begin
          req_nxt.num = slin_pkg::NUM_W'(bprod_r);
          req_nxt.den = slin_pkg::DEN_W'(slin_pkg::BATT_DIV);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else begin
      req_r.vld <= req_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    req_r.kind <= req_nxt.kind;
    req_r.num  <= req_nxt.num;
    req_r.den  <= req_nxt.den;
    req_r.base <= req_nxt.base;
  end

  assign req = req_r;

endmodule

@@ hdl/slin_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module slin_div (
  input  logic               clk,
  input  logic               rst_n,
  input  slin_pkg::div_req_t req,
  output slin_pkg::div_rsp_t rsp
);

  localparam int QW = slin_pkg::Q_W;
  localparam int DW = slin_pkg::DEN_W;

  logic [QW:0]                      vld_r;
  slin_pkg::kind_t                  kind_r [0:QW];
  logic signed [slin_pkg::BASE_W-1:0] base_r [0:QW];
  logic [DW-1:0]                    den_r  [0:QW];
  logic [DW-1:0]                    rem_r  [0:QW];
  logic [QW-1:0]                    nlo_r  [0:QW];
  logic [QW-1:0]                    quo_r  [0:QW];

  // load: upper numerator bits are already below the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    kind_r[0] <= req.kind;
    base_r[0] <= req.base;
    den_r[0]  <= req.den;
    rem_r[0]  <= req.num[slin_pkg::NUM_W-1:QW];
    nlo_r[0]  <= req.num[QW-1:0];
    quo_r[0]  <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem_r[k], nlo_r[k][QW-1]};
    assign ge    = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      kind_r[k+1] <= kind_r[k];
      base_r[k+1] <= base_r[k];
      den_r[k+1]  <= den_r[k];
      rem_r[k+1]  <= ge ? DW'(trial - {1'b0, den_r[k]}) : trial[DW-1:0];
      nlo_r[k+1]  <= {nlo_r[k][QW-2:0], 1'b0};
      quo_r[k+1]  <= {quo_r[k][QW-2:0], ge};
    end
  end

  assign rsp.vld  = vld_r[QW];
  assign rsp.kind = kind_r[QW];
  assign rsp.base = base_r[QW];
  assign rsp.quo  = quo_r[QW];

endmodule

@@ hdl/slin_chk.sv @@
// Port-level checker for the sensor linearizer, bound to the top level.
`timescale 1ns / 1ps

module slin_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [1:0]                          in_action,
  input logic                                out_valid,
  input logic [1:0]                          out_kind,
  input logic signed [slin_pkg::VALUE_W-1:0] out_value
);

  localparam int LAT = slin_pkg::LATENCY;

  // every accepted item yields a result after the fixed latency
  a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("item produced no result");

  // no result without an item
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without item");

  // kind travels with its item
  a_kind_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == $past(in_action, LAT))
    else $error("kind mismatch");

  // temperature stays within the table range
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == slin_pkg::KIND_TEMP) |->
      (out_value >= -15'sd400 && out_value <= 15'sd1200))
    else $error("temperature out of range");

  // throttle stays within 0..1000
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == slin_pkg::KIND_THROTTLE) |->
      (out_value >= 15'sd0 && out_value <= 15'sd1000))
    else $error("throttle out of range");

endmodule

bind sensor_linearizer_core slin_chk u_chk (.*);

@@ verif/sensor_linearizer_checker.sv @@
// Checker for the sensor linearizer: predicts each conversion and compares results.
`timescale 1ns / 1ps

module sensor_linearizer_checker #(
  parameter int VREF_MV       = slin_pkg::VREF_MV_DEF,
  parameter int ADC_FULL_CODE = slin_pkg::ADC_FULL_CODE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [1:0]                          in_action,
  input  logic [slin_pkg::RAW_W-1:0]          in_raw_code,
  input  logic                                out_valid,
  input  logic [1:0]                          out_kind,
  input  logic signed [slin_pkg::VALUE_W-1:0] out_value,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [slin_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slin_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  results_seen
);

  typedef struct {
    slin_pkg::kind_t kind;
    logic [14:0]     value;
  } reading_t;

  reading_t expected_readings[$];

  // Local copy of the configuration registers
  logic [11:0] thr_lo, thr_hi, prs_lo, prs_hi;
  logic [13:0] prs_fs;

  // Thermistor breakpoints, descending millivolts, and their temperatures
  int ntc_pts_mv [10] = '{3250, 3150, 2900, 2500, 1900, 1350, 850, 630, 480, 270};
  int ntc_pts_t  [10] = '{-400, -200, 0, 200, 400, 600, 800, 900, 1000, 1200};

  function automatic longint window_value(longint mv, longint lo, longint hi, longint top);
    if (mv <= lo) return 0;
    if (mv >= hi) return top;
    return (mv - lo) * top / (hi - lo);
  endfunction

  function automatic longint thermistor_tenths(longint mv);
    if (mv >= ntc_pts_mv[0]) return ntc_pts_t[0];
    if (mv <= ntc_pts_mv[9]) return ntc_pts_t[9];
    for (int i = 0; i < 9; i++) begin
      if (mv <= ntc_pts_mv[i] && mv >= ntc_pts_mv[i+1])
        return ntc_pts_t[i] + (ntc_pts_t[i+1] - ntc_pts_t[i]) * (ntc_pts_mv[i] - mv)
               / (ntc_pts_mv[i] - ntc_pts_mv[i+1]);
    end
    return 200;
  endfunction

  function automatic reading_t convert_sample(slin_pkg::kind_t k, logic [11:0] raw);
    reading_t r;
    longint mv, v;
    mv = longint'(raw) * VREF_MV / ADC_FULL_CODE;
    case (k)
      slin_pkg::KIND_TEMP:     v = thermistor_tenths(mv);
      slin_pkg::KIND_THROTTLE: v = window_value(mv, thr_lo, thr_hi, slin_pkg::THR_TOP);
      slin_pkg::KIND_PRESSURE: v = window_value(mv, prs_lo, prs_hi, prs_fs);
      default:                 v = mv * 49 / 10;
    endcase
    if (v > slin_pkg::VALUE_MAX) v = slin_pkg::VALUE_MAX;
    r.kind  = k;
    r.value = v[14:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Watch the three channels at each rising edge
  always @(posedge clk) begin
    reading_t got, want;
    if (!rst_n) begin
      thr_lo = 500; thr_hi = 3000; prs_lo = 200; prs_hi = 3100; prs_fs = 2500;
      expected_readings.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        got.kind  = slin_pkg::kind_t'(out_kind);
        got.value = out_value;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d value=%0d",
                                    out_kind, out_value));
        end else begin
          want = expected_readings.pop_front();
          if (got.kind != want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
          if (got.value != want.value)
            report_mismatch($sformatf("kind %0d value got %0d want %0d", want.kind,
                                      $signed(got.value), $signed(want.value)));
        end
      end
      if (start && !busy)
        expected_readings.push_back(convert_sample(slin_pkg::kind_t'(in_action),
                                                   in_raw_code));
      if (cfg_valid && cfg_ready) begin
        case (slin_pkg::cfg_idx_t'(cfg_index))
          slin_pkg::REG_THR_LO: thr_lo = cfg_wdata[11:0];
          slin_pkg::REG_THR_HI: thr_hi = cfg_wdata[11:0];
          slin_pkg::REG_PRS_LO: prs_lo = cfg_wdata[11:0];
          slin_pkg::REG_PRS_HI: prs_hi = cfg_wdata[11:0];
          slin_pkg::REG_PRS_FS: prs_fs = cfg_wdata[13:0];
          default: ;
        endcase
      end
    end
    pending = expected_readings.size();
  end

endmodule

@@ verif/tb_sensor_linearizer_core.sv @@
// Testbench top for the sensor linearizer: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module tb_sensor_linearizer_core;

  localparam int IDLE_LIMIT = 2000;

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  logic [1:0] in_action, out_kind;
  logic [slin_pkg::RAW_W-1:0] in_raw_code;
  logic signed [slin_pkg::VALUE_W-1:0] out_value;
  logic [slin_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [slin_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int fail_count, pending, results_seen;
  int idle_cycles, items_sent;
  bit timed_out;

  sensor_linearizer_core dut (.*);

  sensor_linearizer_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on cycles with no accepted item, result or write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d results outstanding", pending);
      $display("FAIL sensor_linearizer_core");
      $finish;
    end
  end

  // Write one register, holding valid until it is taken
  task automatic write_reg(slin_pkg::cfg_idx_t idx, int data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data[slin_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_windows(int tl, int th, int pl, int ph, int fs);
    write_reg(slin_pkg::REG_THR_LO, tl);
    write_reg(slin_pkg::REG_THR_HI, th);
    write_reg(slin_pkg::REG_PRS_LO, pl);
    write_reg(slin_pkg::REG_PRS_HI, ph);
    write_reg(slin_pkg::REG_PRS_FS, fs);
  endtask

  // Present one sample; an optional random gap before it
  task automatic send_sample(slin_pkg::kind_t k, int raw, bit allow_gap);
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    start       = 1'b1;
    in_action   = k;
    in_raw_code = raw[slin_pkg::RAW_W-1:0];
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (slin_pkg::LATENCY + 4) @(negedge clk);
  endtask

  // Random samples; raw codes biased toward the range ends 0 and 4095 now and then
  task automatic random_phase(int count, bit allow_gap);
    int raw;
    for (int i = 0; i < count; i++) begin
      raw = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 4095 : 0)
                                        : $urandom_range(0, 4095);
      send_sample(slin_pkg::kind_t'($urandom_range(0, 3)), raw, allow_gap);
    end
  endtask

  initial begin
    int dir_codes[8] = '{0, 1, 335, 1241, 2047, 3102, 4033, 4095};
    start = 1'b0; in_action = '0; in_raw_code = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_wdata = '0;
    idle_cycles = 0; items_sent = 0; timed_out = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: every kind at range ends and table ends (reset config)
    foreach (dir_codes[i])
      for (int k = 0; k < 4; k++) send_sample(slin_pkg::kind_t'(k), dir_codes[i], 1'b0);
    drain();

    // Inverted and empty windows, extreme full scale
    load_windows(3300, 0, 1500, 1500, 10000);
    random_phase(100, 1'b1);
    drain();

    // Widest windows, zero full scale
    load_windows(0, 3300, 0, 3300, 0);
    random_phase(100, 1'b1);
    drain();

    // Random settings, including maximum field values
    for (int p = 0; p < 3; p++) begin
      load_windows($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   (p == 0) ? 16383 : $urandom_range(0, 10000));
      random_phase(80, 1'b1);
      drain();
    end

    // Back to defaults; last stretch back to back with no gaps
    load_windows(500, 3000, 200, 3100, 2500);
    random_phase(120, 1'b0);
    drain();

    $display("covered %0d samples over 6 register settings, %0d results checked",
             items_sent, results_seen);
    $display("inverted, empty and full-range windows and both thermistor clamps exercised");
    if (fail_count == 0)
      $display("PASS sensor_linearizer_core");
    else
      $display("FAIL sensor_linearizer_core");
    $finish;
  end

endmodule
